[hdl/ssaa_pkg.sv]
// Shared types, constants and helpers for the square splat accumulator.
// Used by ssaa_ctrl, ssaa_dp and square_splat_accumulate_argmax.
package ssaa_pkg;

  localparam int GRID_SIZE  = 256;
  localparam int CELL_WIDTH = 32;

  // Row/column index width; memory is addressed by {row, col}.
  localparam int RB        = $clog2(GRID_SIZE);
  localparam int MEM_DEPTH = 2 ** (2 * RB);
  // Width used to work out clipped square bounds (holds coord + radius).
  localparam int BW        = (RB > 9) ? RB + 1 : 10;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] weight;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  best_row;
    logic [7:0]  best_col;
    logic [31:0] best_total;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_FLUSH,
    ST_SCAN,
    ST_SDONE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;    // latch clipped square of the accepted point
    logic start_sweep;  // set bounds to the full grid, clear best
    logic rd_acc;       // read-modify-write at current cell
    logic rd_scan;      // read current cell for arg-max, write zero
    logic clr_wr;       // write zero at current cell
    logic step;         // advance current cell in row-major order
    logic load_out;     // move best into the output register
  } cmd_t;

  typedef struct packed {
    logic empty;        // clipped square of the input point has no cells
    logic at_end;       // current cell is the last of the bounds
    logic out_free;     // output register can take a result this cycle
  } status_t;

  function automatic logic [7:0] idx_to_byte(input logic [RB-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[7:0];
  endfunction

  function automatic logic [31:0] cell_to_word(input logic [CELL_WIDTH-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

endpackage

[hdl/ssaa_ctrl.sv]
// Controller for the square splat accumulator: sequences reset clear,
// per-point read-modify-write, arg-max scan and result hand-off. Uses ssaa_pkg.
module ssaa_ctrl import ssaa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   last_q;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_q <= in_last;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.at_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!status.empty) state_next = ST_ACC;
          else if (in_last)  state_next = ST_SCAN;
        end
      end
      ST_ACC: begin
        if (status.at_end) state_next = last_q ? ST_FLUSH : ST_IDLE;
      end
      // flush state so the last accumulate write lands before the scan reads
      ST_FLUSH:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.at_end) state_next = ST_SDONE;
      end
      ST_SDONE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.step   = 1'b1;
      end
      ST_IDLE: begin
        cmd.load_item   = accept && !status.empty;
        cmd.start_sweep = accept && status.empty && in_last;
      end
      ST_ACC: begin
        cmd.rd_acc = 1'b1;
        cmd.step   = 1'b1;
      end
      ST_FLUSH:  cmd.start_sweep = 1'b1;
      ST_SCAN: begin
        cmd.rd_scan = 1'b1;
        cmd.step    = 1'b1;
      end
      ST_SDONE:  cmd = '0;
      ST_FINISH: cmd.load_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[hdl/ssaa_dp.sv]
// Datapath for the square splat accumulator: radius register, cell cursor,
// cell total memory, saturating add, arg-max tracking, output register. Uses ssaa_pkg.
module ssaa_dp import ssaa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [7:0] cfg_data,
  input  in_req_t  in_data,
  input  cmd_t     cmd,
  output status_t  status,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam logic [BW-1:0] GMAX = BW'(GRID_SIZE - 1);

  logic [7:0]            radius;
  logic [7:0]            w_q;
  logic [RB-1:0]         r_hi, c_lo, c_hi;
  logic [RB-1:0]         cur_r, cur_c;
  logic [2*RB-1:0]       raddr;
  logic                  rd_acc_q, rd_scan_q;
  logic [2*RB-1:0]       acc_addr_q, scan_addr_q;
  logic [CELL_WIDTH-1:0] rdata;
  logic [CELL_WIDTH-1:0] best_val;
  logic [2*RB-1:0]       best_pos;
  logic [CELL_WIDTH-1:0] mem [MEM_DEPTH];

  logic                  we;
  logic [2*RB-1:0]       waddr;
  logic [CELL_WIDTH-1:0] wdata;
  logic [CELL_WIDTH:0]   sum;

  logic [BW-1:0] rr, cc, dd, lo_r, hi_r, lo_c, hi_c, hr_raw, hc_raw;

  // Clipped square of the incoming point
  always_comb begin
    rr     = BW'(in_data.row);
    cc     = BW'(in_data.col);
    dd     = BW'(radius);
    lo_r   = (rr >= dd) ? rr - dd : '0;
    lo_c   = (cc >= dd) ? cc - dd : '0;
    hr_raw = rr + dd;
    hc_raw = cc + dd;
    hi_r   = (hr_raw > GMAX) ? GMAX : hr_raw;
    hi_c   = (hc_raw > GMAX) ? GMAX : hc_raw;
  end

  assign status.empty    = (lo_r > hi_r) || (lo_c > hi_c);
  assign status.at_end   = (cur_r == r_hi) && (cur_c == c_hi);
  assign status.out_free = !out_valid || !out_stall;

  assign raddr = {cur_r, cur_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 8'd1;
    end else if (cfg_we) begin
      radius <= cfg_data;
    end
  end

  // Cursor and bounds; reset points them at the full grid for the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      c_lo  <= '0;
      r_hi  <= RB'(GRID_SIZE - 1);
      c_hi  <= RB'(GRID_SIZE - 1);
      cur_r <= '0;
      cur_c <= '0;
    end else if (cmd.load_item) begin
      c_lo  <= lo_c[RB-1:0];
      r_hi  <= hi_r[RB-1:0];
      c_hi  <= hi_c[RB-1:0];
      cur_r <= lo_r[RB-1:0];
      cur_c <= lo_c[RB-1:0];
    end else if (cmd.start_sweep) begin
      c_lo  <= '0;
      r_hi  <= RB'(GRID_SIZE - 1);
      c_hi  <= RB'(GRID_SIZE - 1);
      cur_r <= '0;
      cur_c <= '0;
    end else if (cmd.step) begin
      if (cur_c == c_hi) begin
        cur_c <= c_lo;
        cur_r <= cur_r + 1'b1;
      end else begin
        cur_c <= cur_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      w_q <= in_data.weight;
    end
    acc_addr_q  <= raddr;
    scan_addr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_acc_q  <= 1'b0;
      rd_scan_q <= 1'b0;
    end else begin
      rd_acc_q  <= cmd.rd_acc;
      rd_scan_q <= cmd.rd_scan;
    end
  end

  // Saturating add on the data read the cycle before
  assign sum = {1'b0, rdata} + (CELL_WIDTH + 1)'(w_q);

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = '0;
    if (rd_acc_q) begin
      we    = 1'b1;
      waddr = acc_addr_q;
      wdata = sum[CELL_WIDTH] ? '1 : sum[CELL_WIDTH-1:0];
    end else if (cmd.rd_scan || cmd.clr_wr) begin
      // scan reads the old total and zeroes the cell on the same edge
      we    = 1'b1;
      waddr = raddr;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sweep) begin
      best_val <= '0;
      best_pos <= '0;
    end else if (rd_scan_q && (rdata > best_val)) begin
      best_val <= rdata;
      best_pos <= scan_addr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.best_row   <= idx_to_byte(best_pos[2*RB-1:RB]);
      out_data.best_col   <= idx_to_byte(best_pos[RB-1:0]);
      out_data.best_total <= cell_to_word(best_val);
    end
  end

  a_one_mem_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_acc, cmd.rd_scan, cmd.clr_wr}))
    else $error("more than one memory operation commanded");

  a_wb_no_clash: assert property (@(posedge clk) disable iff (rst)
    rd_acc_q |-> !(cmd.rd_scan || cmd.clr_wr))
    else $error("accumulate write-back collides with scan or clear write");

  a_rmw_hazard: assert property (@(posedge clk) disable iff (rst)
    (rd_acc_q && cmd.rd_acc) |-> (acc_addr_q != raddr))
    else $error("read of a cell whose update is still pending");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

endmodule

[hdl/square_splat_accumulate_argmax.sv]
// Top level of the square splat accumulator with arg-max read-out.
// Instantiates ssaa_ctrl and ssaa_dp; types from ssaa_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data  (in_req_t)
//   out      output     out_valid / out_stall out_data (out_req_t)
//   cfg      input      cfg_we               cfg_data (radius)
//
// A point covering n cells takes one memory read-modify-write per cell through
// the single-write-port cell memory, then a return to idle. A point marked last
// then starts a scan of the whole grid (after a flush state if it had cells),
// which zeroes each cell as it reads it, and waits until the output register is
// free. After reset a clearing pass over every cell runs before in_stall drops.
// in_stall is high whenever an item is in work; out_stall holds the result.
module square_splat_accumulate_argmax import ssaa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_req_t   out_data
);

  cmd_t    cmd;
  status_t status;

  ssaa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssaa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
